// ----- sv/spc_pkg.sv -----
// Shared types, constants and the CRC-16-CCITT byte update for the
// space packet header CRC checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  localparam logic [15:0] CrcPoly       = 16'h1021;
  localparam logic [15:0] CrcPreset     = 16'hFFFF;
  localparam int unsigned HdrBytes      = 6;
  localparam int unsigned HdrKept       = 4;
  localparam logic [2:0]  NoCrcVerReset = 3'd3;

  localparam logic [2:0] PosHdrKept = 3'(HdrKept);
  localparam logic [2:0] PosHdrFull = 3'(HdrBytes);

  // Snapshot of a packet at its final byte, passed tracker -> result stage
  typedef struct packed {
    logic [3:0][7:0] hdr;       // header bytes 0..3, index 0 first
    logic            crc_zero;  // residue over the whole packet is zero
    logic            short_pkt; // fewer than six bytes arrived
  } spc_pkt_t;

  // Advance the CRC over one byte, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/spc_tracker.sv -----
// Per-packet state: running CRC, byte position and kept header bytes.
// Depends on spc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spc_tracker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            beat_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            last_byte_i,
  output spc_pkg::spc_pkt_t    pkt_o
);

  logic [15:0]     crc_q, crc_d, crc_upd;
  logic [2:0]      pos_q, pos_d, pos_upd;
  logic [3:0][7:0] hdr_q, hdr_d, hdr_upd;

  always_comb begin
    crc_upd = spc_pkg::crc_byte(crc_q, data_byte_i);
    hdr_upd = hdr_q;
    if (pos_q < spc_pkg::PosHdrKept) begin
      hdr_upd[pos_q[1:0]] = data_byte_i;
    end
    pos_upd = (pos_q < spc_pkg::PosHdrFull) ? pos_q + 3'd1 : pos_q;

    pkt_o.hdr       = hdr_upd;
    pkt_o.crc_zero  = (crc_upd == 16'h0000);
    pkt_o.short_pkt = (pos_upd < spc_pkg::PosHdrFull);

    crc_d = crc_q;
    pos_d = pos_q;
    hdr_d = hdr_q;
    if (beat_i) begin
      if (last_byte_i) begin
        // restart for the next packet
        crc_d = spc_pkg::CrcPreset;
        pos_d = 3'd0;
        hdr_d = '0;
      end else begin
        crc_d = crc_upd;
        pos_d = pos_upd;
        hdr_d = hdr_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= spc_pkg::CrcPreset;
      pos_q <= 3'd0;
      hdr_q <= '0;
    end else begin
      crc_q <= crc_d;
      pos_q <= pos_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/spc_result.sv -----
// Result register: decodes header fields and quality, holds them for the
// receiver. Depends on spc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spc_result (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire spc_pkg::spc_pkt_t pkt_i,
  input  wire logic [2:0]        no_crc_version_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [2:0]             version_o,
  output logic                   packet_type_o,
  output logic                   sec_header_present_o,
  output logic [10:0]            apid_o,
  output logic [1:0]             sequence_flags_o,
  output logic [13:0]            sequence_count_o,
  output logic                   crc_checked_o,
  output logic                   crc_ok_o,
  output logic                   short_packet_o,
  output logic                   quality_good_o
);

  logic        valid_q, valid_d;
  logic [2:0]  ver_d;
  logic        chk_d, good_d;

  logic [2:0]  version_q;
  logic        packet_type_q;
  logic        sec_header_present_q;
  logic [10:0] apid_q;
  logic [1:0]  sequence_flags_q;
  logic [13:0] sequence_count_q;
  logic        crc_checked_q;
  logic        crc_ok_q;
  logic        short_packet_q;
  logic        quality_good_q;

  always_comb begin
    ver_d  = pkt_i.hdr[0][7:5];
    chk_d  = (ver_d != no_crc_version_i);
    good_d = !(chk_d && !pkt_i.crc_zero) && !pkt_i.hdr[0][4] && !pkt_i.short_pkt;

    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      version_q            <= ver_d;
      packet_type_q        <= pkt_i.hdr[0][4];
      sec_header_present_q <= pkt_i.hdr[0][3];
      apid_q               <= {pkt_i.hdr[0][2:0], pkt_i.hdr[1]};
      sequence_flags_q     <= pkt_i.hdr[2][7:6];
      sequence_count_q     <= {pkt_i.hdr[2][5:0], pkt_i.hdr[3]};
      crc_checked_q        <= chk_d;
      crc_ok_q             <= pkt_i.crc_zero;
      short_packet_q       <= pkt_i.short_pkt;
      quality_good_q       <= good_d;
    end
  end

  assign out_valid_o          = valid_q;
  assign version_o            = version_q;
  assign packet_type_o        = packet_type_q;
  assign sec_header_present_o = sec_header_present_q;
  assign apid_o               = apid_q;
  assign sequence_flags_o     = sequence_flags_q;
  assign sequence_count_o     = sequence_count_q;
  assign crc_checked_o        = crc_checked_q;
  assign crc_ok_o             = crc_ok_q;
  assign short_packet_o       = short_packet_q;
  assign quality_good_o       = quality_good_q;

endmodule

`default_nettype wire

// ----- sv/space_packet_header_crc_checker.sv -----
// Top level of the space packet header CRC checker.
// Depends on spc_pkg, spc_tracker and spc_result.
//
// Usage:
//   Packet bytes enter on the input channel (in_valid_i / in_ready_o), one
//   beat per byte, header first, last_byte_i high on the final byte. A
//   CRC-16-CCITT runs over every byte; the primary header is decoded.
//   One result beat leaves on the output channel (out_valid_o /
//   out_ready_i) for every packet, in the cycle after its final byte is taken.
//   Throughput is one byte per cycle, but for a final byte held back by a
//   waiting result; the tracker updates the CRC 8 bits in parallel per byte
//   and the result register sits behind it. While a result waits, bytes that
//   are not final are still taken; a final byte waits until the result
//   register is free or being emptied in the same cycle.
//   Reset clears the CRC to 0xFFFF, the byte position and the header bytes,
//   empties the result register and sets the no-CRC version to 3. The
//   no-CRC version is written through cfg_we_i / cfg_wdata_i, by the user
//   only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module space_packet_header_crc_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       version_o,
  output logic             packet_type_o,
  output logic             sec_header_present_o,
  output logic [10:0]      apid_o,
  output logic [1:0]       sequence_flags_o,
  output logic [13:0]      sequence_count_o,
  output logic             crc_checked_o,
  output logic             crc_ok_o,
  output logic             short_packet_o,
  output logic             quality_good_o
);

  logic              beat;
  logic              load;
  logic [2:0]        no_crc_ver_q;
  spc_pkg::spc_pkt_t pkt;

  // Hold the no-CRC version; written whenever the enable is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_crc_ver_q <= spc_pkg::NoCrcVerReset;
    end else if (cfg_we_i) begin
      no_crc_ver_q <= cfg_wdata_i;
    end
  end

  // Stall only a final byte, and only while a result is stuck
  assign in_ready_o = !last_byte_i || !out_valid_o || out_ready_i;
  assign beat       = in_valid_i && in_ready_o;
  assign load       = beat && last_byte_i;

  spc_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .pkt_o       (pkt)
  );

  spc_result u_result (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .load_i               (load),
    .pkt_i                (pkt),
    .no_crc_version_i     (no_crc_ver_q),
    .out_ready_i          (out_ready_i),
    .out_valid_o          (out_valid_o),
    .version_o            (version_o),
    .packet_type_o        (packet_type_o),
    .sec_header_present_o (sec_header_present_o),
    .apid_o               (apid_o),
    .sequence_flags_o     (sequence_flags_o),
    .sequence_count_o     (sequence_count_o),
    .crc_checked_o        (crc_checked_o),
    .crc_ok_o             (crc_ok_o),
    .short_packet_o       (short_packet_o),
    .quality_good_o       (quality_good_o)
  );

  // A final byte that is taken always shows up as a result next cycle
  a_load_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("final byte taken without a result");

  // Input stalls only on a final byte behind an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (last_byte_i && out_valid_o && !out_ready_i))
    else $error("input stalled without cause");

  // Good quality rules out telecommand and short packets
  a_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && quality_good_o) |-> (!packet_type_o && !short_packet_o))
    else $error("good quality on a bad packet");

  // A checked CRC that failed never gives good quality
  a_crc_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && crc_checked_o && !crc_ok_o) |-> !quality_good_o)
    else $error("good quality despite failed CRC");

endmodule

`default_nettype wire
